@@ rtl/lbpch_pkg.sv @@
// Package for the LBP cell histogram block: sizes, payload types and the
// pattern, address and scaling helpers shared by the top level.
// No dependencies.
package lbpch_pkg;

    // Image and cell geometry (image and cell sides are powers of two)
    localparam int IMAGE_SIDE = 128;
    localparam int CELL_SIDE  = 16;
    localparam int GRID_SIDE  = 8;

    localparam int NBINS      = 256;
    localparam int CODE_W     = 8;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = $clog2(IMAGE_SIDE);
    localparam int CELL_LOG2  = $clog2(CELL_SIDE);
    localparam int AREA_LOG2  = 2 * CELL_LOG2;
    localparam int AREA       = CELL_SIDE * CELL_SIDE;
    localparam int CNT_W      = AREA_LOG2 + 1;
    localparam int NCELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int ADDR_W     = CELL_W + CODE_W;
    localparam int NCOUNT     = NCELLS * NBINS;
    localparam int COUNT_DEPTH = 1 << ADDR_W;
    localparam int GRID_LIM   = GRID_SIDE * CELL_SIDE;
    localparam int NORM_W     = CNT_W + 9;
    localparam int BIN_W      = 9;
    localparam int BIN_MAX    = 511;
    localparam int NSITES     = 4;

    localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(IMAGE_SIDE - 1);
    localparam logic [ADDR_W-1:0]  SCRUB_LAST = ADDR_W'(NCOUNT - 1);

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    // Input transaction
    typedef struct packed {
        t_action             action;
        logic [PIX_W-1:0]    pixel_value;
        logic [5:0]          cell_index;
        logic [CODE_W-1:0]   bin_index;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [BIN_W-1:0]    bin_count;
        logic                frame_complete;
    } t_out;

    // 3x3 pixel window, [row][col], row 0 on top, col 2 newest
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    // Item in the window and issue stages
    typedef struct packed {
        logic                valid;
        logic                is_read;
        logic                bank;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                cell_ok;
        logic [ADDR_W-1:0]   raddr;
        logic                done;
    } t_item;

    // One count-memory access in the read-modify-write stage
    typedef struct packed {
        logic                valid;
        logic                is_read;
        logic                bank;
        logic [ADDR_W-1:0]   addr;
        logic                cell_ok;
        logic                done;
    } t_rmw;

    // Count address of one image position
    typedef struct packed {
        logic                ok;
        logic [ADDR_W-1:0]   addr;
    } t_site;

    // Pattern code: bit 7 top-left, clockwise, bit 0 left
    function automatic logic [CODE_W-1:0] lbp_code(input t_win w);
        logic [PIX_W-1:0]  ctr;
        logic [CODE_W-1:0] code;
        ctr     = w[1][1];
        code[7] = (w[0][0] >= ctr);
        code[6] = (w[0][1] >= ctr);
        code[5] = (w[0][2] >= ctr);
        code[4] = (w[1][2] >= ctr);
        code[3] = (w[2][2] >= ctr);
        code[2] = (w[2][1] >= ctr);
        code[1] = (w[2][0] >= ctr);
        code[0] = (w[1][0] >= ctr);
        return code;
    endfunction

    // Cell/bin address of position (r, c); ok is low outside the cell grid
    function automatic t_site site_addr(input logic [COORD_W-1:0] r,
                                        input logic [COORD_W-1:0] c,
                                        input logic [CODE_W-1:0]  code);
        logic [COORD_W-1:0] rr;
        logic [COORD_W-1:0] cc;
        t_site              s;
        rr     = r >> CELL_LOG2;
        cc     = c >> CELL_LOG2;
        s.ok   = (32'(r) < GRID_LIM) && (32'(c) < GRID_LIM);
        s.addr = {CELL_W'(32'(rr) * GRID_SIDE + 32'(cc)), code};
        return s;
    endfunction

    // Round-half-up of count * 256 / area, saturated
    function automatic logic [BIN_W-1:0] norm_count(input logic [CNT_W-1:0] cnt);
        logic [NORM_W-1:0] wide;
        wide = {9'd0, cnt} << 8;
        wide = wide + NORM_W'(AREA / 2);
        wide = wide >> AREA_LOG2;
        if (wide > NORM_W'(BIN_MAX)) begin
            return BIN_W'(BIN_MAX);
        end
        return BIN_W'(wide);
    endfunction

endpackage

@@ rtl/lbp_cell_histogram.sv @@
// LBP cell histogram top level: line buffers, 3x3 window, count banks.
// Depends on lbpch_pkg and lbpch_ram.
//
// Takes one transaction per clock unless stalled. A pixel in the last image
// column or row stalls the input until its extra bin increments have issued,
// most for the final pixel of a frame, because every bin increment is one
// read-modify-write through the single write port of the active count bank;
// all input waits while a read meets a full, stalled result register. Counts
// live in two ping-pong banks of NCOUNT words: the push that starts a frame
// switches banks and the retired bank is cleared in the background, one word
// per cycle while no access to it is in flight. After reset both banks are
// cleared together over all NCOUNT (16384) words, no transaction accepted;
// a frame-start push also waits until the retired bank's clear is done.
module lbp_cell_histogram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lbpch_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lbpch_pkg::t_out   o_out
);
    import lbpch_pkg::*;

    // Front position and frame state
    logic [COORD_W-1:0] r_x, r_y, n_x, n_y;
    logic               r_bank, n_bank;
    logic               r_done, n_done;
    logic               pos0;
    logic               in_acc;
    logic               push_acc;
    t_item              n_item;

    // Pipeline stages
    t_item              r_w;
    logic [PIX_W-1:0]   r_w_px;
    t_win               r_win;
    t_item              r_c;
    logic [NSITES-1:0]  r_c_sent;
    t_rmw               r_b;
    t_rmw               n_b;

    // Flow control
    logic               adv_back;
    logic               adv_front;
    logic               c_more;
    logic               c_fire;
    logic [1:0]         c_sel;
    logic [NSITES-1:0]  c_want;
    logic [NSITES-1:0]  c_pend;
    logic [NSITES-1:0][ADDR_W-1:0] c_addr;

    // Line buffers
    logic [PIX_W-1:0]   row_rd [2];
    logic [PIX_W-1:0]   w_top, w_mid;

    // Count banks and forwarding
    logic [CNT_W-1:0]   cnt_rd [2];
    logic               cnt_we [2];
    logic [ADDR_W-1:0]  cnt_wa [2];
    logic [CNT_W-1:0]   cnt_wd [2];
    logic               r_wb_valid;
    logic               r_wb_bank;
    logic [ADDR_W-1:0]  r_wb_addr;
    logic [CNT_W-1:0]   r_wb_data;
    logic [CNT_W-1:0]   cur;
    logic [CNT_W-1:0]   inc;
    logic               b_write;

    // Background clear
    logic [1:0]         r_scrub_mask;
    logic [ADDR_W-1:0]  r_scrub_addr;
    logic               scrub_busy;
    logic               scrub_conflict;
    logic               scrub_step;

    // Result register
    logic               r_out_valid;
    t_out               r_out;
    logic               out_load;

    // Issue-stage site decode
    logic [COORD_W-1:0] cy1, cx1;
    logic               y_ge1, x_ge1, x_last, y_last, interior;
    logic [CODE_W-1:0]  code;
    t_site              s0, s1, s2, s3;

    //------------------------------------------------------------------
    // Input handshake
    assign pos0       = (r_x == '0) && (r_y == '0);
    assign scrub_busy = |r_scrub_mask;
    assign o_in_stall = !adv_front || (pos0 && scrub_busy);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign push_acc   = in_acc && (i_in.action == ACT_PUSH);

    // Raster position, bank select and frame flag
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_bank = r_bank;
        n_done = r_done;
        if (push_acc) begin
            if (pos0) begin
                n_bank = ~r_bank;
                n_done = 1'b0;
            end
            if (r_x == COORD_LAST) begin
                n_x = '0;
                if (r_y == COORD_LAST) begin
                    n_y    = '0;
                    n_done = 1'b1;
                end else begin
                    n_y = r_y + 1'b1;
                end
            end else begin
                n_x = r_x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_bank <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_bank <= n_bank;
            r_done <= n_done;
        end
    end

    // Accepted transaction as a pipeline item
    always_comb begin
        n_item.valid   = in_acc;
        n_item.is_read = (i_in.action == ACT_READ);
        n_item.bank    = (push_acc && pos0) ? ~r_bank : r_bank;
        n_item.x       = r_x;
        n_item.y       = r_y;
        n_item.cell_ok = (32'(i_in.cell_index) < NCELLS);
        n_item.raddr   = {CELL_W'(i_in.cell_index), i_in.bin_index};
        n_item.done    = r_done;
    end

    //------------------------------------------------------------------
    // Line buffers: even and odd image rows, addressed by column
    for (genvar k = 0; k < 2; k++) begin : g_row
        lbpch_ram #(
            .WIDTH (PIX_W),
            .DEPTH (IMAGE_SIDE)
        ) u_row_ram (
            .i_clk     (i_clk),
            .i_wr_en   (push_acc && (r_y[0] == 1'(k))),
            .i_wr_addr (r_x),
            .i_wr_data (i_in.pixel_value),
            .i_rd_en   (push_acc),
            .i_rd_addr (r_x),
            .o_rd_data (row_rd[k])
        );
    end

    // Same parity holds the row two above, the other parity the row above
    assign w_top = r_w.y[0] ? row_rd[1] : row_rd[0];
    assign w_mid = r_w.y[0] ? row_rd[0] : row_rd[1];

    // Window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w.valid <= 1'b0;
        end else if (adv_front) begin
            r_w <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_front) begin
            r_w_px <= i_in.pixel_value;
        end
    end

    // Shift the window by one column on each push
    always_ff @(posedge i_clk) begin
        if (adv_front && r_w.valid && !r_w.is_read) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= w_top;
            r_win[1][2] <= w_mid;
            r_win[2][2] <= r_w_px;
        end
    end

    //------------------------------------------------------------------
    // Issue stage: the window centers on (y-1, x-1); edge pixels also
    // complete the last column, the last row and the corner
    always_comb begin
        cy1      = r_c.y - 1'b1;
        cx1      = r_c.x - 1'b1;
        y_ge1    = (r_c.y != '0);
        x_ge1    = (r_c.x != '0);
        x_last   = (r_c.x == COORD_LAST);
        y_last   = (r_c.y == COORD_LAST);
        interior = (cy1 != '0) && (cy1 != COORD_LAST) &&
                   (cx1 != '0) && (cx1 != COORD_LAST);
        code     = interior ? lbp_code(r_win) : '0;
        s0       = site_addr(cy1, cx1, code);
        s1       = site_addr(cy1, COORD_LAST, '0);
        s2       = site_addr(COORD_LAST, cx1, '0);
        s3       = site_addr(COORD_LAST, COORD_LAST, '0);
        if (r_c.is_read) begin
            c_want = 4'b0001;
            c_addr = {s3.addr, s2.addr, s1.addr, r_c.raddr};
        end else begin
            c_want[0] = y_ge1 && x_ge1 && s0.ok;
            c_want[1] = x_last && y_ge1 && s1.ok;
            c_want[2] = y_last && x_ge1 && s2.ok;
            c_want[3] = x_last && y_last && s3.ok;
            c_addr    = {s3.addr, s2.addr, s1.addr, s0.addr};
        end
    end

    // Lowest pending access goes first
    always_comb begin
        c_pend = r_c.valid ? (c_want & ~r_c_sent) : '0;
        c_fire = |c_pend;
        c_more = ($countones(c_pend) > 1);
        c_sel  = '0;
        for (int i = NSITES - 1; i >= 0; i--) begin
            if (c_pend[i]) begin
                c_sel = 2'(i);
            end
        end
        n_b.valid   = c_fire;
        n_b.is_read = r_c.is_read;
        n_b.bank    = r_c.bank;
        n_b.addr    = c_addr[c_sel];
        n_b.cell_ok = r_c.cell_ok;
        n_b.done    = r_c.done;
    end

    assign adv_back  = !(r_b.valid && r_b.is_read && r_out_valid && i_out_stall);
    assign adv_front = adv_back && !c_more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
            r_c_sent  <= '0;
        end else if (adv_front) begin
            r_c      <= r_w;
            r_c_sent <= '0;
        end else if (adv_back && c_fire) begin
            r_c_sent <= r_c_sent | (NSITES'(1) << c_sel);
        end
    end

    //------------------------------------------------------------------
    // Count banks: read issued from the issue stage, written back in RMW
    for (genvar k = 0; k < 2; k++) begin : g_bank
        lbpch_ram #(
            .WIDTH (CNT_W),
            .DEPTH (COUNT_DEPTH)
        ) u_cnt_ram (
            .i_clk     (i_clk),
            .i_wr_en   (cnt_we[k]),
            .i_wr_addr (cnt_wa[k]),
            .i_wr_data (cnt_wd[k]),
            .i_rd_en   (adv_back),
            .i_rd_addr (n_b.addr),
            .o_rd_data (cnt_rd[k])
        );
    end

    // RMW stage with forwarding of the previous write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (adv_back) begin
            r_b <= n_b;
        end
    end

    assign b_write = r_b.valid && !r_b.is_read;

    always_comb begin
        if (r_wb_valid && (r_wb_bank == r_b.bank) && (r_wb_addr == r_b.addr)) begin
            cur = r_wb_data;
        end else begin
            cur = cnt_rd[r_b.bank];
        end
        inc = (cur == '1) ? cur : cur + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (adv_back) begin
            r_wb_valid <= b_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_back) begin
            r_wb_bank <= r_b.bank;
            r_wb_addr <= r_b.addr;
            r_wb_data <= inc;
        end
    end

    // Write port per bank: increment of the active bank or clear word
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (b_write && (r_b.bank == 1'(k))) begin
                cnt_we[k] = adv_back;
                cnt_wa[k] = r_b.addr;
                cnt_wd[k] = inc;
            end else begin
                cnt_we[k] = scrub_step && r_scrub_mask[k];
                cnt_wa[k] = r_scrub_addr;
                cnt_wd[k] = '0;
            end
        end
    end

    //------------------------------------------------------------------
    // Background clear; waits while older accesses to that bank are in flight
    assign scrub_conflict = (r_w.valid && r_scrub_mask[r_w.bank]) ||
                            (r_c.valid && r_scrub_mask[r_c.bank]) ||
                            (r_b.valid && r_scrub_mask[r_b.bank]);
    assign scrub_step     = scrub_busy && !scrub_conflict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scrub_mask <= 2'b11;
            r_scrub_addr <= '0;
        end else if (scrub_step) begin
            if (r_scrub_addr == SCRUB_LAST) begin
                r_scrub_mask <= '0;
                r_scrub_addr <= '0;
            end else begin
                r_scrub_addr <= r_scrub_addr + 1'b1;
            end
        end else if (push_acc && pos0) begin
            r_scrub_mask <= 2'b01 << r_bank;
        end
    end

    //------------------------------------------------------------------
    // Result register
    assign out_load = adv_back && r_b.valid && r_b.is_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.bin_count      <= r_b.cell_ok ? norm_count(cur) : '0;
            r_out.frame_complete <= r_b.done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    //------------------------------------------------------------------
    // Checks
    a_start_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && pos0) |-> !scrub_busy)
        else $error("transaction accepted at frame start during bank clear");

    a_done_only_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> pos0)
        else $error("frame complete flag set away from frame start");

    a_issue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_more |=> $stable(r_c))
        else $error("issue stage reloaded with accesses still pending");

    a_no_clear_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scrub_step |-> !(b_write && r_scrub_mask[r_b.bank]))
        else $error("bank clear overlaps a count write-back");

endmodule

@@ rtl/lbpch_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the line buffers and the count banks.
module lbpch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule
